// File: hdl/nnsa_pkg.sv
package nnsa_pkg;

    // Field and register widths fixed by the interface.
    localparam int COL_W      = 10;
    localparam int SRC_DIM_W  = 13;
    localparam int DST_DIM_W  = 11;
    localparam int SADDR_W    = 24;
    localparam int DADDR_W    = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Default size limits.
    localparam int DEF_MAX_SRC_DIM  = 4096;
    localparam int DEF_MAX_DEST_DIM = 1024;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;

    // Register values after reset.
    localparam logic [SRC_DIM_W-1:0] RST_SRC_WIDTH  = 13'd1024;
    localparam logic [SRC_DIM_W-1:0] RST_SRC_HEIGHT = 13'd768;
    localparam logic [DST_DIM_W-1:0] RST_DST_WIDTH  = 11'd240;
    localparam logic [DST_DIM_W-1:0] RST_DST_HEIGHT = 11'd135;

    typedef logic [SRC_DIM_W-1:0] t_src_dim;
    typedef logic [DST_DIM_W-1:0] t_dst_dim;

    // Effective source size: zero reads as one, large values saturate.
    function automatic t_src_dim eff_src(input t_src_dim v, input int unsigned maxv);
        t_src_dim res;
        if (v == '0) begin
            res = t_src_dim'(1);
        end else if (32'(v) > maxv) begin
            res = SRC_DIM_W'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Effective destination size, same rules.
    function automatic t_dst_dim eff_dst(input t_dst_dim v, input int unsigned maxv);
        t_dst_dim res;
        if (v == '0) begin
            res = t_dst_dim'(1);
        end else if (32'(v) > maxv) begin
            res = DST_DIM_W'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: hdl/nearest_neighbor_scale_address_top.sv
// Nearest-neighbor scaling address generator. Each input item is one destination
// pixel (column, row); the result item carries the linear source address
// (source row times source width plus source column), the linear destination
// address (row times target width plus column) and a flag that is set when the
// pixel should be copied. The source column is floor(col * source_width /
// target_width) and the source row is floor(row * source_height / target_height).
// A coordinate outside the target size clears the flag, and both addresses then
// read as zero. The user must write sizes on the configuration port only while
// the block is idle; the block does not enforce this. A size of zero acts as one
// and a size above the limit saturates to it. The block takes one item per clock
// cycle and delivers one result per cycle while the output is not stalled.
// Its stages are one input stage, one multiply stage, one stage per quotient bit
// of the two pipelined restoring dividers that run side by side, and one stage
// that forms the source address. Each stage holds its item only while the
// stage behind it is full and stalled, so bubbles close up and the input keeps
// accepting while a finished result waits at the output, until every stage is full.
module nearest_neighbor_scale_address_top #(
    parameter int MAX_SRC_DIM  = nnsa_pkg::DEF_MAX_SRC_DIM,
    parameter int MAX_DEST_DIM = nnsa_pkg::DEF_MAX_DEST_DIM
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Destination pixel channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [nnsa_pkg::COL_W-1:0]       i_dest_col,
    input  logic [nnsa_pkg::COL_W-1:0]       i_dest_row,
    // Address result channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [nnsa_pkg::SADDR_W-1:0]     o_source_address,
    output logic [nnsa_pkg::DADDR_W-1:0]     o_dest_address,
    output logic                             o_valid_res,
    // Configuration write port.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nnsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nnsa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import nnsa_pkg::*;

    // Inside the target the quotient never reaches the source size, so this many bits suffice.
    localparam int QW   = $clog2(MAX_SRC_DIM);
    localparam int DVDW = COL_W + SRC_DIM_W;
    // Stages: input, multiply, QW divider stages, source address.
    localparam int NS   = QW + 3;
    localparam int DIV0 = 2;

    // Effective sizes, stored already clamped.
    t_src_dim r_sw;
    t_src_dim r_sh;
    t_dst_dim r_tw;
    t_dst_dim r_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= eff_src(RST_SRC_WIDTH, MAX_SRC_DIM);
            r_sh <= eff_src(RST_SRC_HEIGHT, MAX_SRC_DIM);
            r_tw <= eff_dst(RST_DST_WIDTH, MAX_DEST_DIM);
            r_th <= eff_dst(RST_DST_HEIGHT, MAX_DEST_DIM);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SRC_WIDTH:  r_sw <= eff_src(i_cfg_data, MAX_SRC_DIM);
                CFG_SRC_HEIGHT: r_sh <= eff_src(i_cfg_data, MAX_SRC_DIM);
                CFG_DST_WIDTH:  r_tw <= eff_dst(i_cfg_data[DST_DIM_W-1:0], MAX_DEST_DIM);
                CFG_DST_HEIGHT: r_th <= eff_dst(i_cfg_data[DST_DIM_W-1:0], MAX_DEST_DIM);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Per-stage valid bits and load enables. A stage loads when it is empty or
    // when the stage after it moves on.
    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS:0]   en;

    always_comb begin
        en[NS] = !i_out_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign n_v = {r_v[NS-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    assign o_in_stall  = !en[0];
    assign o_out_valid = r_v[NS-1];

    // Stage 0: input register.
    logic [COL_W-1:0] r_dx;
    logic [COL_W-1:0] r_dy;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dx <= i_dest_col;
            r_dy <= i_dest_row;
        end
    end

    // Stage 1: the two dividends, the destination address and the range check.
    // Inside the target size the mapped point always lies inside the source.
    logic [DVDW-1:0]    r_nx;
    logic [DVDW-1:0]    r_ny;
    logic [DADDR_W-1:0] r_dst1;
    logic               r_ok1;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_nx   <= DVDW'(r_dx) * DVDW'(r_sw);
            r_ny   <= DVDW'(r_dy) * DVDW'(r_sh);
            r_dst1 <= DADDR_W'(r_dy) * DADDR_W'(r_tw) + DADDR_W'(r_dx);
            r_ok1  <= (DST_DIM_W'(r_dx) < r_tw) && (DST_DIM_W'(r_dy) < r_th);
        end
    end

    // Divider stages, with the destination address and flag carried alongside.
    logic [QW-1:0]      sx;
    logic [QW-1:0]      sy;
    logic [DADDR_W-1:0] r_pdst [QW];
    logic               r_pok  [QW];

    nnsa_div #(
        .DIVIDEND_W (DVDW),
        .DIVISOR_W  (DST_DIM_W),
        .QUOT_W     (QW)
    ) u_div_x (
        .i_clk      (i_clk),
        .i_en       (en[DIV0 +: QW]),
        .i_dividend (r_nx),
        .i_divisor  (r_tw),
        .o_quotient (sx)
    );

    nnsa_div #(
        .DIVIDEND_W (DVDW),
        .DIVISOR_W  (DST_DIM_W),
        .QUOT_W     (QW)
    ) u_div_y (
        .i_clk      (i_clk),
        .i_en       (en[DIV0 +: QW]),
        .i_dividend (r_ny),
        .i_divisor  (r_th),
        .o_quotient (sy)
    );

    always_ff @(posedge i_clk) begin
        if (en[DIV0]) begin
            r_pdst[0] <= r_dst1;
            r_pok[0]  <= r_ok1;
        end
        for (int k = 1; k < QW; k++) begin
            if (en[DIV0+k]) begin
                r_pdst[k] <= r_pdst[k-1];
                r_pok[k]  <= r_pok[k-1];
            end
        end
    end

    // Last stage: source address, and zeroed fields for a pixel out of range.
    logic [SADDR_W-1:0] r_src;
    logic [DADDR_W-1:0] r_dst;
    logic               r_ok;

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_src <= r_pok[QW-1] ? SADDR_W'(sy) * SADDR_W'(r_sw) + SADDR_W'(sx) : '0;
            r_dst <= r_pok[QW-1] ? r_pdst[QW-1] : '0;
            r_ok  <= r_pok[QW-1];
        end
    end

    assign o_source_address = r_src;
    assign o_dest_address   = r_dst;
    assign o_valid_res      = r_ok;

endmodule

// File: hdl/nnsa_div.sv
module nnsa_div #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 11,
    parameter int QUOT_W     = 12
) (
    input  logic                  i_clk,
    input  logic [QUOT_W-1:0]     i_en,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [QUOT_W-1:0]     o_quotient
);

    // Restoring division, one quotient bit per stage, most significant first.
    // The quotient is exact whenever it fits in QUOT_W bits.
    localparam int RW  = (DIVIDEND_W > DIVISOR_W + QUOT_W) ? DIVIDEND_W
                                                            : DIVISOR_W + QUOT_W;
    localparam int RW1 = RW + 1;

    logic [RW-1:0]     r_rem [QUOT_W];
    logic [QUOT_W-1:0] r_quo [QUOT_W];
    logic [RW-1:0]     n_rem [QUOT_W];
    logic [QUOT_W-1:0] n_quo [QUOT_W];

    function automatic logic [RW:0] f_sub(input logic [RW-1:0] rem,
                                          input logic [DIVISOR_W-1:0] dvs,
                                          input int sh);
        logic [RW:0] shifted;
        shifted = RW1'(dvs) << sh;
        return {1'b0, rem} - shifted;
    endfunction

    always_comb begin
        logic [RW:0] diff;
        diff = f_sub(RW'(i_dividend), i_divisor, QUOT_W - 1);
        n_rem[0] = diff[RW] ? RW'(i_dividend) : diff[RW-1:0];
        n_quo[0] = QUOT_W'(!diff[RW]);
        for (int k = 1; k < QUOT_W; k++) begin
            diff = f_sub(r_rem[k-1], i_divisor, QUOT_W - 1 - k);
            n_rem[k] = diff[RW] ? r_rem[k-1] : diff[RW-1:0];
            n_quo[k] = {r_quo[k-1][QUOT_W-2:0], !diff[RW]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QUOT_W; k++) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quotient = r_quo[QUOT_W-1];

endmodule

// File: hdl/nnsa_chk.sv
module nnsa_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [nnsa_pkg::COL_W-1:0]       i_dest_col,
    input logic [nnsa_pkg::COL_W-1:0]       i_dest_row,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [nnsa_pkg::SADDR_W-1:0]     o_source_address,
    input logic [nnsa_pkg::DADDR_W-1:0]     o_dest_address,
    input logic                             o_valid_res,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [nnsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [nnsa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import nnsa_pkg::*;

    // A result held under stall keeps its fields.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_source_address)
            && $stable(o_dest_address) && $stable(o_valid_res))
        else $error("result changed while stalled");

    // A pixel out of range carries zero addresses.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |-> o_source_address == '0 && o_dest_address == '0)
        else $error("nonzero address on a pixel out of range");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    // With the output free the whole pipeline moves, so the input never stalls.
    a_flow: assert property (@(posedge i_clk)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled while output is free");

endmodule

bind nearest_neighbor_scale_address_top nnsa_chk u_nnsa_chk (.*);

// File: test/nearest_neighbor_scale_address_top_test.sv
`timescale 1ns / 100ps

module nearest_neighbor_scale_address_top_test;

    import nnsa_pkg::*;

    // Size limits the block is built with; the predictor clamps to the same values.
    localparam int unsigned SRC_LIMIT    = DEF_MAX_SRC_DIM;
    localparam int unsigned DST_LIMIT    = DEF_MAX_DEST_DIM;
    // Longest idle stretch either side draws for one item.
    localparam int unsigned MAX_IDLE     = 12;
    // Cycles the receiver holds off during the backpressure test.
    localparam int unsigned HOLD_CYCLES  = 400;
    // The tail wait leaves a wide margin on top of the pipeline depth.
    localparam int unsigned TAIL_CYCLES  = 40;
    // About 700 items, plus holds and register writes, stays far below this.
    localparam int unsigned CYCLE_LIMIT  = 300000;
    // First register index past the list; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_DST_HEIGHT + 1'b1;

    // Expected content of one result item.
    typedef struct packed {
        logic [SADDR_W-1:0] source_address;
        logic [DADDR_W-1:0] dest_address;
        logic               copy_ok;
    } t_pixel_map;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_stall;
    logic [COL_W-1:0]      i_dest_col       = '0;
    logic [COL_W-1:0]      i_dest_row       = '0;
    logic                  o_out_valid;
    logic                  i_out_stall      = 1'b0;
    logic [SADDR_W-1:0]    o_source_address;
    logic [DADDR_W-1:0]    o_dest_address;
    logic                  o_valid_res;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    // The predictor's own copy of the four size registers.
    t_src_dim cfg_src_w = RST_SRC_WIDTH;
    t_src_dim cfg_src_h = RST_SRC_HEIGHT;
    t_dst_dim cfg_dst_w = RST_DST_WIDTH;
    t_dst_dim cfg_dst_h = RST_DST_HEIGHT;

    // Address maps for accepted pixels whose result has not arrived yet.
    t_pixel_map expected_maps[$];

    int          failures    = 0;
    int unsigned cycle_count = 0;
    bit          send_idle   = 1'b1;
    bit          recv_idle   = 1'b1;
    int unsigned stall_wait  = 0;
    int unsigned hold_reqs   = 0;
    int unsigned hold_seen   = 0;
    int unsigned hold_left   = 0;

    nearest_neighbor_scale_address_top #(
        .MAX_SRC_DIM  (SRC_LIMIT),
        .MAX_DEST_DIM (DST_LIMIT)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_dest_col       (i_dest_col),
        .i_dest_row       (i_dest_row),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_source_address (o_source_address),
        .o_dest_address   (o_dest_address),
        .o_valid_res      (o_valid_res),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // A size register of zero acts as one, and anything above the limit acts
    // as the limit.
    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
        if (v == 0) begin
            return 1;
        end
        if (v > maxv) begin
            return maxv;
        end
        return v;
    endfunction

    // Nearest-neighbor mapping of one destination pixel under the current sizes.
    // A pixel outside the target, or one that maps outside the source, gives a
    // result with the flag clear and both addresses zero.
    function automatic t_pixel_map map_pixel(input logic [COL_W-1:0] col,
                                             input logic [COL_W-1:0] row);
        int unsigned sw;
        int unsigned sh;
        int unsigned tw;
        int unsigned th;
        int unsigned sx;
        int unsigned sy;
        t_pixel_map  res;
        sw  = clamp_dim(cfg_src_w, SRC_LIMIT);
        sh  = clamp_dim(cfg_src_h, SRC_LIMIT);
        tw  = clamp_dim(cfg_dst_w, DST_LIMIT);
        th  = clamp_dim(cfg_dst_h, DST_LIMIT);
        sx  = (int'(col) * sw) / tw;
        sy  = (int'(row) * sh) / th;
        res = '0;
        if (col < tw && row < th && sx < sw && sy < sh) begin
            res.source_address = SADDR_W'(sy * sw + sx);
            res.dest_address   = DADDR_W'(int'(row) * tw + int'(col));
            res.copy_ok        = 1'b1;
        end
        return res;
    endfunction

    // Registers keep only as many bits as they are wide; spare indexes do nothing.
    function automatic void apply_size(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SRC_WIDTH: begin
                cfg_src_w = data[SRC_DIM_W-1:0];
            end
            CFG_SRC_HEIGHT: begin
                cfg_src_h = data[SRC_DIM_W-1:0];
            end
            CFG_DST_WIDTH: begin
                cfg_dst_w = data[DST_DIM_W-1:0];
            end
            CFG_DST_HEIGHT: begin
                cfg_dst_h = data[DST_DIM_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // Compares the result item at the output with the oldest pending map.
    task automatic compare_addresses();
        t_pixel_map want;
        if (expected_maps.size() == 0) begin
            $error("result item with nothing pending: source_address %0d dest_address %0d",
                   o_source_address, o_dest_address);
            failures++;
        end else begin
            want = expected_maps.pop_front();
            if (o_source_address !== want.source_address) begin
                $error("source_address: expected %0d, actual %0d",
                       want.source_address, o_source_address);
                failures++;
            end
            if (o_dest_address !== want.dest_address) begin
                $error("dest_address: expected %0d, actual %0d",
                       want.dest_address, o_dest_address);
                failures++;
            end
            if (o_valid_res !== want.copy_ok) begin
                $error("valid_res: expected %0d, actual %0d", want.copy_ok, o_valid_res);
                failures++;
            end
        end
    endtask

    // Result side. Every accepted result is checked against the oldest pending
    // map, then a fresh stall count is drawn for the next item. The long hold
    // from the backpressure test overrides the drawn count while it runs.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            compare_addresses();
            stall_wait = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
        end else if (stall_wait != 0) begin
            stall_wait--;
        end
        i_out_stall <= (stall_wait != 0) || (hold_left != 0);
    end

    // Counts down the long receiver hold. A test requests one by bumping
    // hold_reqs, so this process is the only one that writes the counter.
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog: a run that hangs ends here as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one destination pixel and returns at the edge where it is taken.
    // Valid stays high afterwards so that a following item with no gap goes out
    // on the very next cycle; wait_results_drained lowers it when needed.
    task automatic offer_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_dest_col <= col;
        i_dest_row <= row;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        expected_maps.push_back(map_pixel(col, row));
    endtask

    // Mostly pixels inside the current target frame, where the interesting
    // arithmetic happens; the rest are arbitrary coordinates.
    task automatic offer_random_pixel();
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        if ($urandom_range(0, 3) != 0) begin
            col = COL_W'($urandom_range(0, clamp_dim(cfg_dst_w, DST_LIMIT) - 1));
            row = COL_W'($urandom_range(0, clamp_dim(cfg_dst_h, DST_LIMIT) - 1));
        end else begin
            col = COL_W'($urandom);
            row = COL_W'($urandom);
        end
        offer_pixel(col, row);
    endtask

    // Stops offering and waits until every pending result has come back. Each
    // pixel gives exactly one result, so the pipeline is empty at that point.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_maps.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One register write. Valid is dropped for a cycle after each write so a
    // following write never lowers and raises it in the same step.
    task automatic write_size(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (o_cfg_ready !== 1'b1);
        apply_size(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sizes are only rewritten with the block empty.
    task automatic set_sizes(input logic [CFG_DATA_W-1:0] sw, input logic [CFG_DATA_W-1:0] sh,
                             input logic [CFG_DATA_W-1:0] tw, input logic [CFG_DATA_W-1:0] th);
        wait_results_drained();
        write_size(CFG_SRC_WIDTH, sw);
        write_size(CFG_SRC_HEIGHT, sh);
        write_size(CFG_DST_WIDTH, tw);
        write_size(CFG_DST_HEIGHT, th);
    endtask

    // Source sizes: mostly legal, with zero, tiny and oversized values mixed in.
    function automatic logic [CFG_DATA_W-1:0] pick_src_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DATA_W'($urandom_range(SRC_LIMIT + 1, (1 << SRC_DIM_W) - 1));
            2: return CFG_DATA_W'($urandom_range(1, 8));
            default: return CFG_DATA_W'($urandom_range(1, SRC_LIMIT));
        endcase
    endfunction

    // Target sizes: as above, plus data with bits set above the register width.
    function automatic logic [CFG_DATA_W-1:0] pick_dst_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DATA_W'($urandom_range(DST_LIMIT + 1, (1 << DST_DIM_W) - 1));
            2: return CFG_DATA_W'($urandom_range(1, 8));
            3: return CFG_DATA_W'($urandom) | CFG_DATA_W'(1 << DST_DIM_W);
            default: return CFG_DATA_W'($urandom_range(1, DST_LIMIT));
        endcase
    endfunction

    // Reset sizes (1024x768 down to 240x135): two opposite corners, the first pixel
    // past each edge, the largest coordinate and the centre.
    task automatic test_reset_values();
        offer_pixel(0, 0);
        offer_pixel(239, 134);
        offer_pixel(240, 0);
        offer_pixel(0, 135);
        offer_pixel(1023, 1023);
        offer_pixel(120, 67);
    endtask

    // Zero sizes, the largest legal sizes, oversized registers that must
    // saturate, target data whose upper bits must be dropped, and sizes of one.
    task automatic test_size_extremes();
        set_sizes('0, '0, '0, '0);
        offer_pixel(0, 0);
        offer_pixel(1, 0);
        offer_pixel(0, 1);
        set_sizes(CFG_DATA_W'(SRC_LIMIT), CFG_DATA_W'(SRC_LIMIT),
                  CFG_DATA_W'(DST_LIMIT), CFG_DATA_W'(DST_LIMIT));
        offer_pixel(1023, 1023);
        offer_pixel(0, 1023);
        offer_pixel(1023, 0);
        set_sizes('1, '1, '1, '1);
        offer_pixel(1023, 1023);
        offer_pixel(1, 1);
        // Target width reads as 100 and target height as 0 once masked.
        set_sizes(13'd640, 13'd480, 13'h1000 | 13'd100, 13'h0800);
        offer_pixel(99, 0);
        offer_pixel(100, 0);
        offer_pixel(50, 1);
        set_sizes(13'd1, 13'd1, 13'd1, 13'd1);
        offer_pixel(0, 0);
        offer_pixel(0, 1);
    endtask

    // Writes to indexes past the register list must leave every size alone.
    task automatic test_spare_indexes();
        set_sizes(13'd800, 13'd600, 13'd320, 13'd200);
        for (int k = CFG_SPARE_FIRST; k < (1 << CFG_IDX_W); k++) begin
            write_size(CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(0, 3)));
        end
        offer_pixel(319, 199);
        offer_pixel(160, 100);
        offer_pixel(320, 199);
        offer_pixel(319, 200);
    endtask

    // Bulk of the run: several size settings, the first two at the extremes,
    // each followed by a batch of random pixels with random idling on both sides.
    task automatic test_random_sizes();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_sizes(CFG_DATA_W'(SRC_LIMIT), CFG_DATA_W'(SRC_LIMIT),
                             CFG_DATA_W'(DST_LIMIT), CFG_DATA_W'(DST_LIMIT));
                1: set_sizes(CFG_DATA_W'($urandom_range(1, 4)), CFG_DATA_W'($urandom_range(1, 4)),
                             CFG_DATA_W'($urandom_range(1, 4)), CFG_DATA_W'($urandom_range(1, 4)));
                default: set_sizes(pick_src_size(), pick_src_size(),
                                   pick_dst_size(), pick_dst_size());
            endcase
            repeat (70) offer_random_pixel();
        end
    endtask

    // No idling on either side: one item per cycle through the whole pipeline.
    task automatic test_back_to_back();
        set_sizes(pick_src_size(), pick_src_size(), pick_dst_size(), pick_dst_size());
        send_idle = 1'b0;
        recv_idle = 1'b0;
        repeat (60) offer_random_pixel();
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // The receiver holds off for a long stretch while pixels keep coming, so
    // the pipeline fills and the block has to stall its input.
    task automatic test_output_hold();
        set_sizes(pick_src_size(), pick_src_size(), pick_dst_size(), pick_dst_size());
        send_idle = 1'b0;
        hold_reqs <= hold_reqs + 1;
        repeat (80) offer_random_pixel();
        send_idle = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_size_extremes();
        test_spare_indexes();
        test_random_sizes();
        test_back_to_back();
        test_output_hold();
        wait_results_drained();
        // Any result beyond the expected ones would show up in this window.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
